[sv/lole_pkg.sv]
// ---------------------------------------------------------------------------
// lole_pkg
// shared types and constants of the linked order list engine
// ---------------------------------------------------------------------------
package lole_pkg;

    localparam int MAX_BOXES_DEF = 1024;
    localparam int CMD_W         = 3;
    localparam int BOX_W         = 11;
    localparam int SUM_W         = 20;

    typedef enum logic [CMD_W-1:0] {
        CMD_BEFORE  = 3'd0,
        CMD_AFTER   = 3'd1,
        CMD_SWAP    = 3'd2,
        CMD_REVERSE = 3'd3,
        CMD_INIT    = 3'd4,
        CMD_REPORT  = 3'd5
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_Y,
        ST_RD_X,
        ST_DECIDE,
        ST_WRITE,
        ST_INIT,
        ST_WALK0,
        ST_WALK,
        ST_FIX,
        ST_DONE
    } state_t;

endpackage

[sv/linked_order_list_engine_unit.sv]
// ---------------------------------------------------------------------------
// linked_order_list_engine_unit
// box order kept as a circular doubly linked list in two link rams
// ---------------------------------------------------------------------------
// one command at a time; a new command is accepted only in idle
// move and swap: two link reads, one decide, 3 or 4 writes, one result
// already satisfied move: no writes; reverse and rejected commands go straight to the result
// init: one write per entry; report: chained link reads
// the result step waits while the output register holds an unaccepted beat
// reset clears the reversed flag and sets box_count to 1; links are valid after init
module linked_order_list_engine_unit #(
    parameter int MAX_BOXES = lole_pkg::MAX_BOXES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data,   // box_count
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // command[2:0], box_x[13:3], box_y[24:14], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // odd_position_sum[19:0], zero pad
    output logic [0:0]  m_tuser     // ignored
);

    localparam int DEPTH = MAX_BOXES + 1;
    localparam int IW    = $clog2(DEPTH);
    localparam int CW    = (2 * IW > lole_pkg::SUM_W) ? 2 * IW : lole_pkg::SUM_W;
    localparam int SW    = lole_pkg::SUM_W;
    localparam int BW    = lole_pkg::BOX_W;

    lole_pkg::state_t state_reg, state_next;

    logic [lole_pkg::CMD_W-1:0] cmd_reg, cmd_next;
    logic [BW-1:0]              x_reg, x_next, y_reg, y_next;
    logic [BW-1:0]              count_reg;
    logic                       rev_reg, rev_next;
    logic                       ign_reg, ign_next;
    logic [SW-1:0]              sum_reg, sum_next;
    logic [CW-1:0]              total_reg, total_next;
    logic [IW-1:0]              i_reg, i_next;
    logic [IW-1:0]              ny_reg, ny_next, py_reg, py_next;
    logic [IW-1:0]              ja_reg [4];
    logic [IW-1:0]              jb_reg [4];
    logic [IW-1:0]              ja_next [4];
    logic [IW-1:0]              jb_next [4];
    logic [1:0]                 jk_reg, jk_next, jlast_reg, jlast_next;

    // link ram ports
    logic          n_we, p_we;
    logic [IW-1:0] n_waddr, n_wdata, p_waddr, p_wdata, raddr;
    logic [IW-1:0] n_rdata, p_rdata;

    // result handoff
    logic out_valid, out_ready;

    // input fields
    logic [lole_pkg::CMD_W-1:0] in_cmd;
    logic [BW-1:0]              in_x, in_y;
    logic [IW-1:0]              n_eff;
    logic                       in_bad;

    assign in_cmd = s_tdata[2:0];
    assign in_x   = s_tdata[13:3];
    assign in_y   = s_tdata[24:14];

    assign n_eff = (32'(count_reg) > 32'(MAX_BOXES)) ? IW'(MAX_BOXES) : IW'(count_reg);

    assign in_bad = (in_x == '0) || (in_y == '0) || (in_x == in_y)
                 || (32'(in_x) > 32'(n_eff)) || (32'(in_y) > 32'(n_eff));

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == lole_pkg::ST_IDLE);

    // move and swap decision from the y links (registered) and the x links (ram out)
    logic          d_swap, d_before, d_after, d_ign;
    logic [IW-1:0] dx, dy, lx, rx, ly, ry;

    always_comb
    begin
        d_swap = (cmd_reg == lole_pkg::CMD_SWAP) && (ny_reg == IW'(x_reg));
        if (d_swap)
        begin
            dx = IW'(y_reg);
            dy = IW'(x_reg);
            lx = py_reg;
            rx = ny_reg;
            ly = p_rdata;
            ry = n_rdata;
        end
        else
        begin
            dx = IW'(x_reg);
            dy = IW'(y_reg);
            lx = p_rdata;
            rx = n_rdata;
            ly = py_reg;
            ry = ny_reg;
        end
        d_before = (cmd_reg == lole_pkg::CMD_BEFORE && !rev_reg)
                || (cmd_reg == lole_pkg::CMD_AFTER && rev_reg);
        d_after  = (cmd_reg == lole_pkg::CMD_AFTER && !rev_reg)
                || (cmd_reg == lole_pkg::CMD_BEFORE && rev_reg);
        d_ign    = (d_before && ly == dx) || (d_after && ry == dx);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lole_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (in_cmd) inside
                        lole_pkg::CMD_BEFORE, lole_pkg::CMD_AFTER, lole_pkg::CMD_SWAP:
                            state_next = in_bad ? lole_pkg::ST_DONE : lole_pkg::ST_RD_Y;
                        lole_pkg::CMD_INIT:   state_next = lole_pkg::ST_INIT;
                        lole_pkg::CMD_REPORT: state_next = lole_pkg::ST_WALK0;
                        default:              state_next = lole_pkg::ST_DONE;
                    endcase
                end
            end
            lole_pkg::ST_RD_Y:   state_next = lole_pkg::ST_RD_X;
            lole_pkg::ST_RD_X:   state_next = lole_pkg::ST_DECIDE;
            lole_pkg::ST_DECIDE: state_next = d_ign ? lole_pkg::ST_DONE : lole_pkg::ST_WRITE;
            lole_pkg::ST_WRITE:
            begin
                if (jk_reg == jlast_reg)
                begin
                    state_next = lole_pkg::ST_DONE;
                end
            end
            lole_pkg::ST_INIT:
            begin
                if (i_reg == n_eff)
                begin
                    state_next = lole_pkg::ST_DONE;
                end
            end
            lole_pkg::ST_WALK0:
            begin
                state_next = (n_eff == '0) ? lole_pkg::ST_FIX : lole_pkg::ST_WALK;
            end
            lole_pkg::ST_WALK:
            begin
                if (i_reg == n_eff)
                begin
                    state_next = lole_pkg::ST_FIX;
                end
            end
            lole_pkg::ST_FIX:    state_next = lole_pkg::ST_DONE;
            lole_pkg::ST_DONE:
            begin
                if (out_ready)
                begin
                    state_next = lole_pkg::ST_IDLE;
                end
            end
            default:             state_next = lole_pkg::ST_IDLE;
        endcase
    end

    // datapath and ram control
    logic [SW:0]   sum_add;
    logic [CW-1:0] sum_ext;
    logic [CW-1:0] prod;

    assign sum_add = {1'b0, sum_reg} + (SW + 1)'(n_rdata);
    assign sum_ext = CW'(sum_reg);
    assign prod    = CW'(n_eff) * CW'({1'b0, n_eff} + 1'b1);

    always_comb
    begin
        cmd_next   = cmd_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        rev_next   = rev_reg;
        ign_next   = ign_reg;
        sum_next   = sum_reg;
        total_next = total_reg;
        i_next     = i_reg;
        ny_next    = ny_reg;
        py_next    = py_reg;
        jk_next    = jk_reg;
        jlast_next = jlast_reg;
        for (int k = 0; k < 4; k++)
        begin
            ja_next[k] = ja_reg[k];
            jb_next[k] = jb_reg[k];
        end
        n_we      = 1'b0;
        p_we      = 1'b0;
        n_waddr   = '0;
        n_wdata   = '0;
        p_waddr   = '0;
        p_wdata   = '0;
        raddr     = IW'(y_reg);
        out_valid = 1'b0;

        unique case (state_reg)
            lole_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next = in_cmd;
                    x_next   = in_x;
                    y_next   = in_y;
                    sum_next = '0;
                    ign_next = 1'b0;
                    i_next   = '0;
                    case (in_cmd) inside
                        lole_pkg::CMD_BEFORE, lole_pkg::CMD_AFTER, lole_pkg::CMD_SWAP:
                            ign_next = in_bad;
                        lole_pkg::CMD_REVERSE: rev_next = !rev_reg;
                        lole_pkg::CMD_INIT:    rev_next = 1'b0;
                        lole_pkg::CMD_REPORT:  ign_next = 1'b0;
                        default:               ign_next = 1'b1;
                    endcase
                end
            end
            lole_pkg::ST_RD_Y:
            begin
                raddr = IW'(y_reg);
            end
            lole_pkg::ST_RD_X:
            begin
                raddr   = IW'(x_reg);
                ny_next = n_rdata;
                py_next = p_rdata;
            end
            lole_pkg::ST_DECIDE:
            begin
                ign_next = d_ign;
                jk_next  = '0;
                if (d_before)
                begin
                    ja_next[0] = lx; jb_next[0] = rx;
                    ja_next[1] = ly; jb_next[1] = dx;
                    ja_next[2] = dx; jb_next[2] = dy;
                    jlast_next = 2'd2;
                end
                else if (d_after)
                begin
                    ja_next[0] = lx; jb_next[0] = rx;
                    ja_next[1] = dy; jb_next[1] = dx;
                    ja_next[2] = dx; jb_next[2] = ry;
                    jlast_next = 2'd2;
                end
                else if (rx == dy)
                begin
                    // neighbors: x and y adjacent, dx directly before dy
                    ja_next[0] = lx; jb_next[0] = dy;
                    ja_next[1] = dy; jb_next[1] = dx;
                    ja_next[2] = dx; jb_next[2] = ry;
                    jlast_next = 2'd2;
                end
                else
                begin
                    ja_next[0] = lx; jb_next[0] = dy;
                    ja_next[1] = dy; jb_next[1] = rx;
                    ja_next[2] = ly; jb_next[2] = dx;
                    ja_next[3] = dx; jb_next[3] = ry;
                    jlast_next = 2'd3;
                end
            end
            lole_pkg::ST_WRITE:
            begin
                n_we    = 1'b1;
                n_waddr = ja_reg[jk_reg];
                n_wdata = jb_reg[jk_reg];
                p_we    = 1'b1;
                p_waddr = jb_reg[jk_reg];
                p_wdata = ja_reg[jk_reg];
                jk_next = jk_reg + 2'd1;
            end
            lole_pkg::ST_INIT:
            begin
                n_we    = 1'b1;
                p_we    = 1'b1;
                n_waddr = i_reg;
                p_waddr = i_reg;
                if (i_reg == '0)
                begin
                    // sentinel
                    n_wdata = (n_eff == '0) ? '0 : IW'(1);
                    p_wdata = n_eff;
                end
                else
                begin
                    n_wdata = (i_reg == n_eff) ? '0 : i_reg + 1'b1;
                    p_wdata = i_reg - 1'b1;
                end
                i_next = i_reg + 1'b1;
            end
            lole_pkg::ST_WALK0:
            begin
                raddr      = '0;
                i_next     = IW'(1);
                total_next = prod >> 1;
            end
            lole_pkg::ST_WALK:
            begin
                raddr  = n_rdata;
                i_next = i_reg + 1'b1;
                if (i_reg[0])
                begin
                    sum_next = sum_add[SW] ? {SW{1'b1}} : sum_add[SW-1:0];
                end
            end
            lole_pkg::ST_FIX:
            begin
                if (rev_reg && !n_eff[0])
                begin
                    sum_next = (sum_ext <= total_reg) ? SW'(total_reg - sum_ext) : '0;
                end
            end
            lole_pkg::ST_DONE:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lole_pkg::ST_IDLE;
            rev_reg   <= 1'b0;
            count_reg <= BW'(1);
        end
        else
        begin
            state_reg <= state_next;
            rev_reg   <= rev_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        ign_reg   <= ign_next;
        sum_reg   <= sum_next;
        total_reg <= total_next;
        i_reg     <= i_next;
        ny_reg    <= ny_next;
        py_reg    <= py_next;
        jk_reg    <= jk_next;
        jlast_reg <= jlast_next;
        for (int k = 0; k < 4; k++)
        begin
            ja_reg[k] <= ja_next[k];
            jb_reg[k] <= jb_next[k];
        end
    end

    lole_ram #(
        .WIDTH (IW),
        .DEPTH (DEPTH)
    ) u_next_ram (
        .clk   (clk),
        .we    (n_we),
        .waddr (n_waddr),
        .wdata (n_wdata),
        .raddr (raddr),
        .rdata (n_rdata)
    );

    lole_ram #(
        .WIDTH (IW),
        .DEPTH (DEPTH)
    ) u_prev_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (raddr),
        .rdata (p_rdata)
    );

    lole_obuf u_obuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (out_valid),
        .in_ready   (out_ready),
        .in_sum     (sum_reg),
        .in_ignored (ign_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

[sv/lole_ram.sv]
// ---------------------------------------------------------------------------
// lole_ram
// simple dual port ram, one write port, one read port with registered data
// ---------------------------------------------------------------------------
module lole_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1025
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/lole_obuf.sv]
// ---------------------------------------------------------------------------
// lole_obuf
// output register stage for result beats
// ---------------------------------------------------------------------------
module lole_obuf (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [lole_pkg::SUM_W-1:0] in_sum,
    input  logic                      in_ignored,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [23:0]               m_tdata,  // odd_position_sum[19:0], zero pad
    output logic [0:0]                m_tuser   // ignored
);

    logic                       valid_reg;
    logic [lole_pkg::SUM_W-1:0] sum_reg;
    logic                       ign_reg;

    assign in_ready = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            sum_reg <= in_sum;
            ign_reg <= in_ignored;
        end
    end

    assign m_tvalid   = valid_reg;
    assign m_tdata    = {{(24 - lole_pkg::SUM_W){1'b0}}, sum_reg};
    assign m_tuser[0] = ign_reg;

endmodule
